FILE: rtl/pairwise_point_distance_macros.svh
// ---------------------------------------------------------------------------
// pairwise_point_distance assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PAIRWISE_POINT_DISTANCE_MACROS_SVH
`define PAIRWISE_POINT_DISTANCE_MACROS_SVH

// property given in full
`define PPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define PPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/ppd_pkg.sv
// ---------------------------------------------------------------------------
// ppd_pkg
// Widths, latencies and constant tables of the point distance pipeline.
// ---------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned EUCL_RAD_W = 66;
  localparam int unsigned GEO_RAD_W  = 62;
  localparam int unsigned TRIG_LAT   = 28;
  localparam int unsigned COS_STEPS  = 10;
  localparam int unsigned ASIN_TERMS = 8;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [28:0] RADIUS_Q16  = 29'd418014036;

  // exact floor(y / n) for y < 2^32: (y * COS_RCP) >> COS_SHIFT
  localparam logic [32:0] COS_RCP [COS_STEPS] = '{
    33'(((64'd1 << 41) + 64'd379) / 64'd380),
    33'(((64'd1 << 41) + 64'd305) / 64'd306),
    33'(((64'd1 << 40) + 64'd239) / 64'd240),
    33'(((64'd1 << 40) + 64'd181) / 64'd182),
    33'(((64'd1 << 40) + 64'd131) / 64'd132),
    33'(((64'd1 << 39) + 64'd89) / 64'd90),
    33'(((64'd1 << 38) + 64'd55) / 64'd56),
    33'(((64'd1 << 37) + 64'd29) / 64'd30),
    33'(((64'd1 << 36) + 64'd11) / 64'd12),
    33'(((64'd1 << 33) + 64'd1) / 64'd2)
  };

  localparam int unsigned COS_SHIFT [COS_STEPS] = '{41, 41, 40, 40, 40, 39, 38, 37, 36, 33};

  localparam logic signed [31:0] ASIN_COEF [ASIN_TERMS] = '{
    32'sd1686629690, -32'sd230423709, 32'sd95540460, -32'sd53874249,
    32'sd33169905, -32'sd18348235, 32'sd7161953, -32'sd1355590
  };

endpackage

FILE: rtl/ppd_trig.sv
// ---------------------------------------------------------------------------
// ppd_trig
// Pipelined cosine of a signed Q17.16 degree angle: Q30 magnitude plus sign.
// ---------------------------------------------------------------------------
module ppd_trig
  import ppd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] ang_i,
  output logic [30:0]        mag_o,
  output logic               neg_o
);

  localparam int unsigned XD_D  = 2 * COS_STEPS - 2;
  localparam int unsigned NEG_D = TRIG_LAT - 4;

  function automatic logic [30:0] cos_t(input logic [64:0] qp, input int unsigned sh);
    logic [64:0] d;
    d = qp >> sh;
    return (d >= 65'(Q30_ONE)) ? 31'd0 : 31'(65'(Q30_ONE) - d);
  endfunction

  // degrees -> binary angle
  logic signed [18:0] vs;
  logic [17:0] v1_r, v2_r;
  logic [15:0] lo1_r, lo2_r;
  logic [36:0] pq2_r;
  logic [9:0]  q3;
  logic [17:0] mh;
  logic [24:0] m3, m3_r;
  logic [50:0] pa3_r;
  logic [18:0] a4;
  logic [18:0] a4_r;
  logic [5:0]  b4;
  logic [38:0] pb4_r;
  logic [31:0] p5;
  logic [30:0] u5, u5_r;
  logic [61:0] px6_r, px7_r;
  logic [30:0] x7;

  // cosine Horner
  logic [62:0] prod_r [COS_STEPS];
  logic [62:0] prod_nxt [COS_STEPS];
  logic [64:0] qp_r [COS_STEPS];
  logic [64:0] qp_nxt [COS_STEPS];
  logic [31:0] xd_r [XD_D];
  logic        ng_r [NEG_D];
  logic [30:0] mag_r;
  logic [31:0] x2s;
  logic [30:0] ts;

  always_comb begin
    vs = 19'($signed(ang_i[32:16])) + 19'sd65880;
    q3 = pq2_r[36:27];
    mh = 18'(v2_r - 18'(18'(q3) * 18'd360));
    m3 = {mh[8:0], lo2_r};
    a4 = pa3_r[49:31];
    b4 = 6'(m3_r - 25'(25'(a4) * 25'd45));
    p5 = {a4_r, 13'd0} + 32'(pb4_r[38:25]);
    u5 = p5[30] ? 31'(Q30_ONE - {1'b0, p5[29:0]}) : {1'b0, p5[29:0]};
    x7 = px6_r[60:30];
    for (int i = 0; i < COS_STEPS; i++) begin
      if (i == 0) begin
        x2s = px7_r[61:30];
        ts  = Q30_ONE;
      end else begin
        x2s = xd_r[2*i-1];
        ts  = cos_t(qp_r[i-1], COS_SHIFT[i-1]);
      end
      prod_nxt[i] = 63'(x2s) * 63'(ts);
      qp_nxt[i]   = 65'(prod_r[i][62:30]) * 65'(COS_RCP[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r  <= vs[17:0];
      lo1_r <= ang_i[15:0];
      pq2_r <= 37'(v1_r) * 37'(19'd372828);
      v2_r  <= v1_r;
      lo2_r <= lo1_r;
      pa3_r <= 51'(m3) * 51'(26'd47721859);
      m3_r  <= m3;
      pb4_r <= 39'({b4, 13'd0}) * 39'(20'd745655);
      a4_r  <= a4;
      u5_r  <= u5;
      px6_r <= 62'(u5_r) * 62'(HALF_PI_Q30);
      px7_r <= 62'(x7) * 62'(x7);
      for (int i = 0; i < COS_STEPS; i++) begin
        prod_r[i] <= prod_nxt[i];
        qp_r[i]   <= qp_nxt[i];
      end
      xd_r[0] <= px7_r[61:30];
      for (int k = 1; k < XD_D; k++) begin
        xd_r[k] <= xd_r[k-1];
      end
      ng_r[0] <= p5[31] ^ p5[30];
      for (int k = 1; k < NEG_D; k++) begin
        ng_r[k] <= ng_r[k-1];
      end
      mag_r <= cos_t(qp_r[COS_STEPS-1], COS_SHIFT[COS_STEPS-1]);
    end
  end

  assign mag_o = mag_r;
  assign neg_o = ng_r[NEG_D-1];

endmodule

FILE: rtl/ppd_sqrt.sv
// ---------------------------------------------------------------------------
// ppd_sqrt
// Pipelined integer square root, one root bit per register stage.
// ---------------------------------------------------------------------------
module ppd_sqrt
  import ppd_pkg::*;
#(
  parameter  int unsigned RAD_W  = EUCL_RAD_W,
  localparam int unsigned ROOT_W = RAD_W / 2
)
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r [ROOT_W];
  logic [REM_W-1:0]  rem_nxt [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [RAD_W-1:0]  rad_r [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt [ROOT_W];
  logic [REM_W-1:0]  rem_p, rem_s, trial;
  logic [ROOT_W-1:0] root_p;
  logic [RAD_W-1:0]  rad_p;

  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      if (j == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = rad_i;
      end else begin
        rem_p  = rem_r[j-1];
        root_p = root_r[j-1];
        rad_p  = rad_r[j-1];
      end
      rem_s = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      trial = {root_p, 2'b01};
      if (rem_s >= trial) begin
        rem_nxt[j]  = rem_s - trial;
        root_nxt[j] = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = rem_s;
        root_nxt[j] = {root_p[ROOT_W-2:0], 1'b0};
      end
      rad_nxt[j] = {rad_p[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        rad_r[j]  <= rad_nxt[j];
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];

endmodule

FILE: rtl/pairwise_point_distance.sv
// ---------------------------------------------------------------------------
// pairwise_point_distance
// Euclidean or haversine great-circle distance of one point pair per request.
// ---------------------------------------------------------------------------
// One request carries points A and B (signed Q16.16, degrees in geographic
// mode); one result (unsigned Q17.16) comes back per request, in order.
// The pipeline is 97 register stages deep: the request is taken into stage 1
// at its accepting edge, and its result leaves from the last stage. A new
// request is taken every cycle while out_ready is high or the
// output stage is empty. The depth is set by the geographic path: the cosine
// Horner chain (two stages per term), then two 31-stage square roots in a
// row (haversine root, then sqrt(1-s) for asin). The Euclidean path (one
// 33-stage root of the 66-bit sum of squares) runs alongside and is delayed
// to the same depth. When the output stage is held, the whole pipeline
// holds and in_ready drops. geographic_mode may only be written while no
// request is in flight; cfg_ready is always high.
// ---------------------------------------------------------------------------
module pairwise_point_distance
  import ppd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_ax,
  input  logic signed [COORD_W-1:0] in_ay,
  input  logic signed [COORD_W-1:0] in_bx,
  input  logic signed [COORD_W-1:0] in_by,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DIST_W-1:0]         out_distance,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_geographic_mode
);

  localparam int unsigned LAT    = 97;
  localparam int unsigned HORN   = ASIN_TERMS - 1;
  localparam int unsigned SD_D   = 2 * HORN - 2;
  localparam int unsigned PDL_D  = 17;   // Horner done at 77, root at 94
  localparam int unsigned EQ_D   = 60;   // Euclidean root at 36, out at 97

  function automatic logic [30:0] hav(input logic [30:0] m, input logic n);
    logic [31:0] s;
    s = n ? (32'(Q30_ONE) + 32'(m)) : (32'(Q30_ONE) - 32'(m));
    return s[31:1];
  endfunction

  logic adv;
  logic [LAT-1:0] vld_r;
  logic mode_r;

  // stage 1
  logic signed [32:0] ay1_r, by1_r, dlat1_r, dlon1_r;

  // Euclidean
  logic [32:0] mx, my;
  logic [65:0] sqx2_r, sqy2_r, sum3_r;
  logic [32:0] eroot;
  logic [32:0] eq_r [EQ_D];

  // geographic
  logic [30:0] ca, cb, mlat, mlon;
  logic        na, nb, nlat, nlon;
  logic [61:0] pcc_r, pt_r;
  logic [30:0] hlat_r, hlon_r, hlat2_r, hq_r;
  logic        sg_r, sg2_r;
  logic signed [32:0] h;
  logic [30:0] s_root, sw_root;
  logic [30:0] sd_r [SD_D];
  logic [63:0] aprod_r [HORN];
  logic [63:0] aprod_nxt [HORN];
  logic        an_r [HORN];
  logic        an_nxt [HORN];
  logic signed [32:0] p_r [HORN];
  logic signed [32:0] p_nxt [HORN];
  logic signed [32:0] pdl_r [PDL_D];
  logic signed [32:0] pv;
  logic [32:0] pmag;
  logic [30:0] sv;
  logic [31:0] am;
  logic [31:0] pc;
  logic [62:0] ptv_r;
  logic [32:0] tq;
  logic [30:0] ang;
  logic [60:0] pd_r;
  logic [DIST_W-1:0] dist_r;

  // the whole pipe moves unless a finished result is held
  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_valid) begin
        mode_r <= cfg_geographic_mode;
      end
    end
  end

  ppd_trig u_trig_ay (.clk(clk), .en(adv), .ang_i(ay1_r),   .mag_o(ca),   .neg_o(na));
  ppd_trig u_trig_by (.clk(clk), .en(adv), .ang_i(by1_r),   .mag_o(cb),   .neg_o(nb));
  ppd_trig u_trig_la (.clk(clk), .en(adv), .ang_i(dlat1_r), .mag_o(mlat), .neg_o(nlat));
  ppd_trig u_trig_lo (.clk(clk), .en(adv), .ang_i(dlon1_r), .mag_o(mlon), .neg_o(nlon));

  ppd_sqrt #(.RAD_W(EUCL_RAD_W)) u_sqrt_eu (
    .clk(clk), .en(adv), .rad_i(sum3_r), .root_o(eroot)
  );

  // haversine root: sqrt(h * 2^30)
  ppd_sqrt #(.RAD_W(GEO_RAD_W)) u_sqrt_h (
    .clk(clk), .en(adv), .rad_i({1'b0, hq_r, 30'd0}), .root_o(s_root)
  );

  // sqrt(1 - s) for the asin form
  ppd_sqrt #(.RAD_W(GEO_RAD_W)) u_sqrt_w (
    .clk(clk), .en(adv), .rad_i({1'b0, 31'(Q30_ONE - s_root), 30'd0}), .root_o(sw_root)
  );

  always_comb begin
    mx = dlon1_r[32] ? 33'(-dlon1_r) : 33'(dlon1_r);
    my = dlat1_r[32] ? 33'(-dlat1_r) : 33'(dlat1_r);

    h = sg2_r ? (33'(hlat2_r) - 33'(pt_r[60:30])) : (33'(hlat2_r) + 33'(pt_r[60:30]));

    // asin polynomial, two stages per term
    for (int j = 0; j < HORN; j++) begin
      if (j == 0) begin
        sv = s_root;
        pv = 33'(ASIN_COEF[ASIN_TERMS-1]);
      end else begin
        sv = sd_r[2*j-1];
        pv = p_r[j-1];
      end
      pmag = pv[32] ? 33'(-pv) : 33'(pv);
      aprod_nxt[j] = 64'(pmag) * 64'(sv);
      an_nxt[j]    = pv[32];
      am           = aprod_r[j][61:30];
      p_nxt[j]     = 33'(ASIN_COEF[HORN-1-j]) + (an_r[j] ? 33'(-33'(am)) : 33'(am));
    end

    pc  = pdl_r[PDL_D-1][32] ? 32'd0 : pdl_r[PDL_D-1][31:0];
    tq  = ptv_r[62:30];
    ang = (tq >= 33'(HALF_PI_Q30)) ? 31'd0 : 31'(33'(HALF_PI_Q30) - tq);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ay1_r   <= 33'(in_ay);
      by1_r   <= 33'(in_by);
      dlat1_r <= 33'(in_by) - 33'(in_ay);
      dlon1_r <= 33'(in_bx) - 33'(in_ax);

      sqx2_r <= 66'(mx) * 66'(mx);
      sqy2_r <= 66'(my) * 66'(my);
      sum3_r <= sqx2_r + sqy2_r;
      eq_r[0] <= eroot;
      for (int k = 1; k < EQ_D; k++) begin
        eq_r[k] <= eq_r[k-1];
      end

      pcc_r  <= 62'(ca) * 62'(cb);
      hlat_r <= hav(mlat, nlat);
      hlon_r <= hav(mlon, nlon);
      sg_r   <= na ^ nb;

      pt_r    <= 62'(pcc_r[60:30]) * 62'(hlon_r);
      hlat2_r <= hlat_r;
      sg2_r   <= sg_r;

      // clamp to [0, 1]
      if (h[32]) begin
        hq_r <= 31'd0;
      end else if (h > 33'sd1073741824) begin
        hq_r <= Q30_ONE;
      end else begin
        hq_r <= h[30:0];
      end

      sd_r[0] <= s_root;
      for (int k = 1; k < SD_D; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      for (int j = 0; j < HORN; j++) begin
        aprod_r[j] <= aprod_nxt[j];
        an_r[j]    <= an_nxt[j];
        p_r[j]     <= p_nxt[j];
      end
      pdl_r[0] <= p_r[HORN-1];
      for (int k = 1; k < PDL_D; k++) begin
        pdl_r[k] <= pdl_r[k-1];
      end

      ptv_r  <= 63'(sw_root) * 63'(pc);
      pd_r   <= 61'({ang, 1'b0}) * 61'(RADIUS_Q16);
      dist_r <= mode_r ? DIST_W'(pd_r[60:30]) : eq_r[EQ_D-1];
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_distance = dist_r;

endmodule

FILE: rtl/ppd_checker.sv
// ---------------------------------------------------------------------------
// ppd_checker
// Port-level checks of the distance pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`include "pairwise_point_distance_macros.svh"

module ppd_checker
  import ppd_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [DIST_W-1:0]         out_distance,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  // held result stays put
  `PPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_distance), "result changed while held")
  // empty output stage never blocks requests
  `PPD_ASSERT_IMP(a_empty_ready, !out_valid, in_ready, "in_ready low with empty output")
  // a draining output lets the pipe move
  `PPD_ASSERT_IMP(a_drain_ready, out_ready, in_ready, "in_ready low while output drains")
  `PPD_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind pairwise_point_distance ppd_checker u_ppd_checker (.*);

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// Point distance pipeline testbench
// Drives point pairs through the pipeline in Euclidean and great-circle
// modes with random bursts and output stalls, and checks every distance
// against a bit-exact fixed-point predictor held in a scoreboard class.
// ---------------------------------------------------------------------------
module tb
  import ppd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Q1       = 64'd1073741824;
  localparam longint unsigned HALF_PI  = 64'd1686629713;
  localparam longint unsigned RADIUS   = 64'd418014036;
  localparam longint          TURN     = 64'sd23592960;
  localparam longint unsigned DMAX     = 64'd8589934591;
  localparam int              PIPE_LAT = 97;

  // Fixed-point distance predictor, one entry queued per accepted request.
  class distance_scoreboard;
    logic [DIST_W-1:0] pending[$];
    bit                geo;
    int                errors;
    int                checked;

    // floor(sqrt(hi*2^64 + lo)), hi < 4
    function automatic longint unsigned int_sqrt(longint unsigned hi, longint unsigned lo);
      longint unsigned root, rem, pr, trial;
      root = 0;
      rem  = 0;
      for (int k = 32; k >= 0; k--) begin
        pr    = (k == 32) ? (hi & 3) : ((lo >> (2 * k)) & 3);
        rem   = (rem << 2) | pr;
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function automatic longint unsigned to_phase(longint r);
      longint m;
      m = r % TURN;
      if (m < 0) m = m + TURN;
      return (longint'(m) * 65536) / 360;
    endfunction

    function automatic longint unsigned cos_abs(longint unsigned ph, output bit neg);
      longint unsigned q, f, u, x, x2, t, d;
      int unsigned divs[10] = '{380, 306, 240, 182, 132, 90, 56, 30, 12, 2};
      q  = (ph >> 30) & 3;
      f  = ph & 64'h3FFF_FFFF;
      u  = q[0] ? (Q1 - f) : f;
      x  = (u * HALF_PI) >> 30;
      x2 = (x * x) >> 30;
      t  = Q1;
      for (int i = 0; i < 10; i++) begin
        d = ((x2 * t) >> 30) / divs[i];
        t = (d >= Q1) ? 0 : (Q1 - d);
      end
      neg = (q == 1) || (q == 2);
      return t;
    endfunction

    function automatic longint unsigned haversine(longint unsigned ph);
      bit n;
      longint unsigned m;
      m = cos_abs(ph, n);
      return n ? ((Q1 + m) >> 1) : ((Q1 - m) >> 1);
    endfunction

    function automatic longint great_circle(longint ax, longint ay, longint bx, longint by);
      bit na, nb, neg;
      longint unsigned ca, cb, hlat, hlon, term, s, w, sw, t, ang, ma, mb;
      longint h, p, prod;
      ca   = cos_abs(to_phase(ay), na);
      cb   = cos_abs(to_phase(by), nb);
      hlat = haversine(to_phase(by - ay));
      hlon = haversine(to_phase(bx - ax));
      term = (((ca * cb) >> 30) * hlon) >> 30;
      h    = (na != nb) ? longint'(hlat) - longint'(term) : longint'(hlat) + longint'(term);
      if (h < 0) h = 0;
      if (h > longint'(Q1)) h = Q1;
      s  = int_sqrt(0, longint'(h) << 30);
      w  = Q1 - s;
      sw = int_sqrt(0, w << 30);
      p  = ASIN_COEF[7];
      for (int i = 6; i >= 0; i--) begin
        neg  = (p < 0);
        ma   = neg ? -p : p;
        mb   = s;
        prod = longint'((ma * mb) >> 30);
        p    = longint'(ASIN_COEF[i]) + (neg ? -prod : prod);
      end
      if (p < 0) p = 0;
      t   = (sw * longint'(p)) >> 30;
      ang = (t >= HALF_PI) ? 0 : (HALF_PI - t);
      return ((2 * ang) * RADIUS) >> 30;
    endfunction

    function void note_request(logic signed [31:0] ax, ay, bx, by);
      longint unsigned d, mx, my, sx, sy, lo, hi;
      longint dx, dy;
      if (geo) begin
        d = great_circle(ax, ay, bx, by);
      end else begin
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        sx = mx * mx;
        sy = my * my;
        lo = sx + sy;
        hi = (lo < sx) ? 1 : 0;
        d  = int_sqrt(hi, lo);
      end
      if (d > DMAX) d = DMAX;
      pending.push_back(d[DIST_W-1:0]);
    endfunction

    function void check_result(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("distance %0d with no request pending", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want)
        report_mismatch($sformatf("distance got %0d want %0d", got, want));
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [COORD_W-1:0] in_ax = 0, in_ay = 0, in_bx = 0, in_by = 0;
  logic out_valid, out_ready = 0;
  logic [DIST_W-1:0] out_distance;
  logic cfg_valid = 0, cfg_ready, cfg_geographic_mode = 0;

  distance_scoreboard sb = new();
  bit hold_off = 0;       // long receiver stall request
  int unsigned sent_total = 0;

  pairwise_point_distance DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // sample requests and results at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_ax, in_ay, in_bx, in_by);
    if (rst_n && out_valid && out_ready) sb.check_result(out_distance);
  end

  // receiver: own stall pattern, plus the long hold-off
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      mode = (sent_total / 300) % 3;
      if (hold_off) out_ready <= 0;
      else if (mode == 0) out_ready <= 1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 1) != 0);
    end
  end

  // one request, held until accepted; optional idle gap afterwards
  task automatic send_pair(logic signed [31:0] ax, ay, bx, by, int gap);
    in_valid <= 1;
    in_ax <= ax; in_ay <= ay; in_bx <= bx; in_by <= by;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic idle_then_config(bit geo_on);
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
    cfg_valid <= 1;
    cfg_geographic_mode <= geo_on;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.geo = geo_on;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // coordinate generator: full range, longitude-like or latitude-like degrees
  function automatic logic signed [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 360 * 65536)) - 180 * 65536;
      default: return $signed($urandom_range(0, 180 * 65536)) - 90 * 65536;
    endcase
  endfunction

  task automatic random_phase(int count);
    int burst, kind;
    logic signed [31:0] ax, ay;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 3);
      ax = rand_coord(kind == 0 ? 0 : 1);
      ay = rand_coord(kind == 0 ? 0 : 2);
      if (burst == 0) burst = $urandom_range(1, 40);
      burst--;
      if (kind == 3)      // nearby point, small differences
        send_pair(ax, ay, ax + $signed($urandom_range(0, 8192)) - 4096,
                  ay + $signed($urandom_range(0, 8192)) - 4096,
                  burst == 0 ? $urandom_range(1, 12) : 0);
      else
        send_pair(ax, ay, rand_coord(kind == 0 ? 0 : 1), rand_coord(kind == 0 ? 0 : 2),
                  burst == 0 ? $urandom_range(1, 12) : 0);
    end
  endtask

  task automatic directed_phase();
    localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINC = 32'sh8000_0000;
    localparam logic signed [31:0] D90  = 90 * 65536;
    localparam logic signed [31:0] D180 = 180 * 65536;
    send_pair(0, 0, 0, 0, 0);
    send_pair(MAXC, MAXC, MINC, MINC, 0);        // largest differences
    send_pair(MINC, MAXC, MAXC, MINC, 1);
    send_pair(MAXC, MINC, MAXC, MINC, 0);
    send_pair(-1, -1, 0, 0, 0);
    send_pair(0, D90, 0, -D90, 2);               // pole to pole
    send_pair(0, 0, D180, 0, 0);                 // antipodal on equator
    send_pair(10 * 65536, D90 + 65536, 5, -D90 - 65536, 0); // beyond poles
    send_pair(720 * 65536 + 1, 45 * 65536, -360 * 65536, 45 * 65536, 0); // wrap
    send_pair(0, 0, 1, 0, 0);                    // tiny distance
    send_pair(D180, 0, -D180, 0, 0);
    send_pair(12345, 67890, -23456, 78901, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    directed_phase();
    idle_then_config(1);
    directed_phase();
    random_phase(500);
    idle_then_config(0);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_phase(500);
    join
    idle_then_config(1);
    random_phase(500);
    idle_then_config(0);
    random_phase(400);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    $display("Covered %0d requests in both modes: corner coordinates, poles, wraps,",
             sent_total);
    $display("burst gaps, output stalls and a long backpressure hold; %0d distances checked.",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ppd_pkg.sv
rtl/ppd_trig.sv
rtl/ppd_sqrt.sv
rtl/pairwise_point_distance.sv
rtl/ppd_checker.sv
tb/tb.sv
